/* hdl/pfq_pkg.sv */
// Package for the PIFO fair queue scheduler: payload structs and status codes.
// No dependencies.
`timescale 1ns / 1ps
package pfq_pkg;
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  flow_id;
    logic [15:0] flow_weight;
    logic [15:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [7:0]  out_flow;
    logic [31:0] out_rank;
  } out_item_t;
endpackage

/* hdl/pifo_fair_queue_scheduler.sv */
// PIFO fair queue scheduler top level: sequencer, slot scan and result register.
// Depends on pfq_pkg, pfq_slot_mem and pfq_flow_mem.
//
// Usage: items enter on in_valid/in_ready as in_item_t; each yields exactly one
// result on out_valid/out_ready as out_item_t. cfg_valid/cfg_ready writes
// total_flows (reset 255); write it only while the block is idle.
// An enqueue reads the flow memory while it walks the used bits to find the
// lowest free slot; a dequeue reads every slot from the slot memory, one
// address a cycle, tracking the minimum rank. One item is in flight at a time.
// The result sits in an output register; the next item is taken while it
// waits, and the sequencer holds at its result step only if the register is
// still full. Reset clears used bits, flow valid bits, the virtual round and
// the result valid bit; no clearing pass.
`timescale 1ns / 1ps
module pifo_fair_queue_scheduler #(
  parameter int SLOTS = 32,
  parameter int FLOWS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfq_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfq_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import pfq_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int FW = $clog2(FLOWS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FLOW = 5'b00010,
    S_SCAN = 5'b00100,
    S_LAST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  in_item_t    item_r;
  logic [7:0]  total_r;
  logic [31:0] round_r;
  logic [SLOTS-1:0] used_r;
  logic [CW-1:0] idx_r;
  logic [31:0] rank_r;
  logic        found_r;
  logic [SW-1:0] best_r;
  logic [31:0] best_rank_r;
  logic [15:0] best_handle_r;
  logic [7:0]  best_flow_r;
  logic        cand_vld_r;
  logic [SW-1:0] cand_r;
  out_item_t   res_r;
  logic        res_vld_r;

  logic [55:0] slot_rd;
  logic [31:0] flow_rd;
  logic        tracked;
  logic        flow_wr;
  logic        slot_wr;
  logic [32:0] fin_sum;
  logic [31:0] fin;

  assign tracked = (item_r.flow_id <= total_r) && ({24'd0, item_r.flow_id} < FLOWS);
  assign fin_sum = {1'b0, rank_r} + {17'd0, item_r.flow_weight};
  assign fin     = fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  wire done_go = (state_r == S_DONE) && (!res_vld_r || out_ready);
  assign slot_wr = done_go && item_r.operation == OP_ENQ && found_r;
  assign flow_wr = slot_wr && tracked;

  pfq_slot_mem #(.SLOTS(SLOTS)) u_slot (
    .clk    (clk),
    .rd_addr(idx_r[SW-1:0]),
    .rd_data(slot_rd),
    .wr_en  (slot_wr),
    .wr_addr(best_r),
    .wr_data({rank_r, item_r.packet_handle, item_r.flow_id})
  );

  pfq_flow_mem #(.FLOWS(FLOWS)) u_flow (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_addr(item_r.flow_id[FW-1:0]),
    .rd_data(flow_rd),
    .wr_en  (flow_wr),
    .wr_addr(item_r.flow_id[FW-1:0]),
    .wr_data(fin)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_FLOW;
      S_FLOW: state_nxt = S_SCAN;
      S_SCAN: if (idx_r == CW'(SLOTS - 1)) state_nxt = S_LAST;
      S_LAST: state_nxt = S_DONE;
      S_DONE: if (!res_vld_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= 8'd255;
      round_r   <= '0;
      used_r    <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) total_r <= cfg_data;
      if (out_valid && out_ready) res_vld_r <= 1'b0;
      if (done_go) begin
        res_vld_r <= 1'b1;
        if (item_r.operation == OP_ENQ) begin
          if (found_r) used_r[best_r] <= 1'b1;
        end else if (found_r) begin
          used_r[best_r] <= 1'b0;
          round_r        <= best_rank_r;
        end
      end
    end
  end

  // datapath: the compare sees a scan address in the cycle after it is issued (registered memory read)
  always_ff @(posedge clk) begin
    cand_vld_r <= 1'b0;
    unique case (state_r)
      S_IDLE: begin
        item_r  <= in_data;
        idx_r   <= '0;
        found_r <= 1'b0;
      end
      S_FLOW: begin
        idx_r  <= idx_r + 1'b1;
        cand_r <= idx_r[SW-1:0];
        cand_vld_r <= 1'b1;
      end
      S_SCAN, S_LAST: begin
        if (state_r == S_SCAN) begin
          idx_r      <= idx_r + 1'b1;
          cand_r     <= idx_r[SW-1:0];
          cand_vld_r <= 1'b1;
        end
        if (item_r.operation == OP_ENQ) begin
          // first cycle here: flow memory data is valid
          if (idx_r == CW'(1)) begin
            rank_r <= (tracked && flow_rd > round_r) ? flow_rd : round_r;
          end
          if (cand_vld_r && !found_r && !used_r[cand_r]) begin
            found_r <= 1'b1;
            best_r  <= cand_r;
          end
        end else if (cand_vld_r && used_r[cand_r] &&
                     (!found_r || slot_rd[55:24] < best_rank_r)) begin
          found_r       <= 1'b1;
          best_r        <= cand_r;
          best_rank_r   <= slot_rd[55:24];
          best_handle_r <= slot_rd[23:8];
          best_flow_r   <= slot_rd[7:0];
        end
      end
      S_DONE: begin
        if (done_go) begin
          if (item_r.operation == OP_ENQ) begin
            res_r.status     <= found_r ? ST_ENQUEUED : ST_DROPPED;
            res_r.out_handle <= '0;
            res_r.out_flow   <= item_r.flow_id;
            res_r.out_rank   <= rank_r;
          end else if (found_r) begin
            res_r.status     <= ST_DEQUEUED;
            res_r.out_handle <= best_handle_r;
            res_r.out_flow   <= best_flow_r;
            res_r.out_rank   <= best_rank_r;
          end else begin
            res_r <= '{status: ST_EMPTY, out_handle: '0, out_flow: '0, out_rank: '0};
          end
        end
      end
      default: ;
    endcase
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_ready |=> state_r == S_FLOW)
    else $error("accepted item not started");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
      done_go |=> out_valid)
    else $error("finished item gave no result");
endmodule

/* hdl/pfq_flow_mem.sv */
// Flow finish-round memory with epoch-free fill by valid bits per entry.
// Depends on nothing; one write port, one registered read port.
`timescale 1ns / 1ps
module pfq_flow_mem #(
  parameter int FLOWS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [$clog2(FLOWS)-1:0] rd_addr,
  output logic [31:0]              rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(FLOWS)-1:0] wr_addr,
  input  logic [31:0]              wr_data
);
  logic [31:0]      mem [FLOWS];
  logic [FLOWS-1:0] vld_r;
  logic [31:0]      raw_r;
  logic             hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    raw_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      hit_r <= vld_r[rd_addr];
    end
  end

  // unwritten flows read as zero
  assign rd_data = hit_r ? raw_r : 32'd0;
endmodule

/* hdl/pfq_slot_mem.sv */
// Slot store: rank, handle and flow per slot in one memory; used bits live in top-level flops.
// Depends on pfq_pkg-free plain types; one write, one registered read port.
`timescale 1ns / 1ps
module pfq_slot_mem #(
  parameter int SLOTS = 32
) (
  input  logic                     clk,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic [55:0]              rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic [55:0]              wr_data
);
  logic [55:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

/* test/pfq_checker.sv */
// Checker for the PIFO fair queue scheduler: watches the item and config channels,
// predicts each result with its own scheduler state and compares. Depends on pfq_pkg.
`timescale 1ns / 1ps
module pfq_checker #(
  parameter int SLOTS = 32,
  parameter int FLOWS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pfq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pfq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import pfq_pkg::*;

  logic        used_q [SLOTS];
  logic [31:0] rank_q [SLOTS];
  logic [15:0] handle_q [SLOTS];
  logic [7:0]  flow_q [SLOTS];
  logic [31:0] finish_round [FLOWS];
  logic [31:0] vround;
  logic [7:0]  tracked_limit;
  out_item_t   expected_results [$];

  assign pending = expected_results.size();

  function automatic out_item_t schedule_item(in_item_t it);
    out_item_t r;
    int free_slot;
    int best;
    logic tracked;
    logic [32:0] fin;
    r = '0;
    if (it.operation == OP_ENQ) begin
      tracked = (it.flow_id <= tracked_limit) && (int'(it.flow_id) < FLOWS);
      r.out_rank = vround;
      if (tracked && finish_round[it.flow_id] > vround) r.out_rank = finish_round[it.flow_id];
      r.out_flow = it.flow_id;
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!used_q[i]) free_slot = i;
      if (free_slot < 0) begin
        r.status = ST_DROPPED;
      end else begin
        r.status = ST_ENQUEUED;
        used_q[free_slot] = 1'b1;
        rank_q[free_slot] = r.out_rank;
        handle_q[free_slot] = it.packet_handle;
        flow_q[free_slot] = it.flow_id;
        if (tracked) begin
          fin = {1'b0, r.out_rank} + it.flow_weight;
          finish_round[it.flow_id] = fin[32] ? 32'hFFFF_FFFF : fin[31:0];
        end
      end
    end else begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (used_q[i] && (best < 0 || rank_q[i] < rank_q[best])) best = i;
      if (best < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_DEQUEUED;
        used_q[best] = 1'b0;
        vround = rank_q[best];
        r.out_handle = handle_q[best];
        r.out_flow = flow_q[best];
        r.out_rank = rank_q[best];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) used_q[i] = 1'b0;
      for (int i = 0; i < FLOWS; i++) finish_round[i] = '0;
      vround = '0;
      tracked_limit = 8'd255;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) tracked_limit = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e.status != out_data.status || e.out_handle != out_data.out_handle ||
              e.out_flow != out_data.out_flow || e.out_rank != out_data.out_rank) begin
            $display("%0t: expected st=%0d h=%h f=%h r=%h, got st=%0d h=%h f=%h r=%h",
                     $time, e.status, e.out_handle, e.out_flow, e.out_rank,
                     out_data.status, out_data.out_handle, out_data.out_flow,
                     out_data.out_rank);
            fail_count <= fail_count + 1;
          end
        end
      end
      // append the prediction at the tail of the queue
      if (in_valid && in_ready) expected_results = {expected_results, schedule_item(in_data)};
    end
  end
endmodule

/* test/testbench.sv */
// Top of the scheduler test: drives enqueue/dequeue items and config writes,
// stalls the result side and gives the verdict. Depends on pfq_pkg, pfq_checker, the RTL.
`timescale 1ns / 1ps
module testbench;
  import pfq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;
  int        fail_count;
  int        pending;
  int        hold_off = 0;
  int        enq_bias = 60;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pifo_fair_queue_scheduler #(.SLOTS(32), .FLOWS(256)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  pfq_checker #(.SLOTS(32), .FLOWS(256)) checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
  );

  // Receiver: random stalls, quiet stretches, and long hold-offs on request.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if ((($time / 4000) % 3) == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 65);
    end
  end

  // Keep valid high after acceptance; the caller drops it before any gap.
  task automatic send_item(logic op, logic [7:0] fid, logic [15:0] w, logic [15:0] h);
    in_valid <= 1'b1;
    in_data <= '{operation: op, flow_id: fid, flow_weight: w, packet_handle: h};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random;
    logic [7:0] fid;
    if ($urandom_range(0, 99) < enq_bias) begin
      fid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
      send_item(OP_ENQ, fid, ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40)),
                16'($urandom));
    end else begin
      send_item(OP_DEQ, 8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int gap;
    for (int i = 0; i < n; i++) begin
      send_random();
      if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty dequeue, extremes, ties, untracked flow.
    send_item(OP_DEQ, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_ENQ, 8'h00, 16'h0000, 16'h0000);
    send_item(OP_ENQ, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_ENQ, 8'h01, 16'h0000, 16'h1234);
    send_item(OP_ENQ, 8'h00, 16'h0005, 16'h5555);
    for (int i = 0; i < 4; i++) send_item(OP_DEQ, 8'h00, 16'h0, 16'h0);
    for (int i = 0; i < 3; i++) send_item(OP_ENQ, 8'hFF, 16'hFFFF, 16'(i));
    drain();
    write_limit(8'd0);
    send_item(OP_ENQ, 8'h05, 16'h0010, 16'hAAAA);
    send_item(OP_ENQ, 8'h00, 16'h0010, 16'hBBBB);
    for (int i = 0; i < 6; i++) send_item(OP_DEQ, 8'h00, 16'h0, 16'h0);
    drain();
    // Fill past capacity with the receiver held off so the input stalls.
    write_limit(8'd255);
    hold_off <= 300;
    for (int i = 0; i < 34; i++) send_item(OP_ENQ, 8'(i % 4), 16'(i), 16'(i));
    drain();
    random_phase(150);
    drain();
    write_limit(8'd3);
    enq_bias = 50;
    random_phase(150);
    drain();
    write_limit(8'd128);
    enq_bias = 75;
    random_phase(150);
    drain();
    write_limit(8'd255);
    enq_bias = 55;
    random_phase(150);
    drain();
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

/* pifo_fair_queue_scheduler.f */
hdl/pfq_pkg.sv
hdl/pfq_flow_mem.sv
hdl/pfq_slot_mem.sv
hdl/pifo_fair_queue_scheduler.sv
test/pfq_checker.sv
test/testbench.sv
